// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PALE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PALE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/pale_pkg.sv =====
// Types, constants and codes of the positional array list engine.
`default_nettype none

package pale_pkg;

   localparam int DEPTH  = 1024;
   localparam int WIDTH  = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int FUNC_W = 2;
   localparam int POS_W  = 11;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 3;
   localparam int LEN_W  = 11;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_FIELD_W = POS_W + VAL_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = POS_W + VAL_W + LEN_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 2'd0,
      FN_ERASE  = 2'd1,
      FN_ALTER  = 2'd2,
      FN_SEARCH = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 3'd0,
      STAT_RANGE = 3'd1,
      STAT_FULL  = 3'd2,
      STAT_EMPTY = 3'd3,
      STAT_MISS  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_ERASE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] raddr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WIDTH-1:0]  wdata;
   } mem_req_type;

   typedef struct packed {
      status_type       status;
      logic [POS_W-1:0] found_position;
      logic [VAL_W-1:0] removed_value;
   } res_type;

endpackage

`default_nettype wire

// ===== src/pale_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pale_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/pale_seq.sv =====
// Sequencer: checks requests and walks the entry store for insert, erase and search.
`default_nettype none

module pale_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire pale_pkg::func_type            req_func,
   input  wire logic [pale_pkg::POS_W-1:0]    req_position,
   input  wire logic [pale_pkg::VAL_W-1:0]    req_value,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output pale_pkg::res_type                  res,
   output logic      [pale_pkg::LEN_W-1:0]    res_length,
   output pale_pkg::mem_req_type              mem_req,
   input  wire logic [pale_pkg::WIDTH-1:0]    mem_rdata
);

   localparam int ADDR_W = pale_pkg::ADDR_W;
   localparam int CNT_W  = pale_pkg::CNT_W;
   localparam int POS_W  = pale_pkg::POS_W;
   localparam int CMP_W  = pale_pkg::CMP_W;
   localparam int WIDTH  = pale_pkg::WIDTH;
   localparam int VAL_W  = pale_pkg::VAL_W;

   pale_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [WIDTH-1:0]    val_ff, val_in;
   pale_pkg::res_type   res_ff, res_in;

   logic [CMP_W-1:0] req_pos_c;
   logic [CMP_W-1:0] cnt_c;
   logic             ins_range_bad;
   logic             rw_range_bad;
   logic             list_full;
   logic             list_empty;
   logic             more_down;
   logic             more_up;
   logic             hit;

   // request checks, done in the accept cycle
   assign req_pos_c     = CMP_W'(req_position);
   assign cnt_c         = CMP_W'(cnt_ff);
   assign list_full     = (cnt_ff == CNT_W'(pale_pkg::DEPTH));
   assign list_empty    = (cnt_ff == '0);
   assign ins_range_bad = (req_position == '0) || (req_pos_c > cnt_c + CMP_W'(1));
   assign rw_range_bad  = (req_position == '0) || (req_pos_c > cnt_c);

   // walk conditions
   assign more_down = (CMP_W'(idx_ff) >= CMP_W'(pos_ff));
   assign more_up   = (idx_ff < cnt_ff);
   assign hit       = pend_ff && (mem_rdata == val_ff);

   assign req_ready  = (state_ff == pale_pkg::ST_IDLE);
   assign res_valid  = (state_ff == pale_pkg::ST_FINISH);
   assign res        = res_ff;
   assign res_length = pale_pkg::LEN_W'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pale_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  pale_pkg::FN_INSERT: begin
                     state_in = (ins_range_bad || list_full) ? pale_pkg::ST_FINISH
                                                             : pale_pkg::ST_INSERT;
                  end
                  pale_pkg::FN_ERASE: begin
                     state_in = (list_empty || rw_range_bad) ? pale_pkg::ST_FINISH
                                                             : pale_pkg::ST_ERASE;
                  end
                  pale_pkg::FN_SEARCH: begin
                     state_in = pale_pkg::ST_SEARCH;
                  end
                  default: begin
                     state_in = pale_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         pale_pkg::ST_INSERT: begin
            if (!pend_ff && !more_down) begin
               state_in = pale_pkg::ST_FINISH;
            end
         end
         pale_pkg::ST_ERASE: begin
            if (!pend_ff && !more_up) begin
               state_in = pale_pkg::ST_FINISH;
            end
         end
         pale_pkg::ST_SEARCH: begin
            if (hit || (!pend_ff && !more_up)) begin
               state_in = pale_pkg::ST_FINISH;
            end
         end
         pale_pkg::ST_FINISH: begin
            if (res_ready) begin
               state_in = pale_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pale_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory requests
   always_comb begin
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      mem_req      = '0;
      case (state_ff)
         pale_pkg::ST_IDLE: begin
            if (req_valid) begin
               pos_in                = req_position;
               val_in                = WIDTH'(req_value);
               res_in.status         = pale_pkg::STAT_OK;
               res_in.found_position = '0;
               res_in.removed_value  = '0;
               idx_in                = '0;
               case (req_func)
                  pale_pkg::FN_INSERT: begin
                     idx_in = cnt_ff;
                     if (ins_range_bad) begin
                        res_in.status = pale_pkg::STAT_RANGE;
                     end else if (list_full) begin
                        res_in.status = pale_pkg::STAT_FULL;
                     end
                  end
                  pale_pkg::FN_ERASE, pale_pkg::FN_ALTER: begin
                     idx_in = CNT_W'(req_position) - CNT_W'(1);
                     if (list_empty) begin
                        res_in.status = pale_pkg::STAT_EMPTY;
                     end else if (rw_range_bad) begin
                        res_in.status = pale_pkg::STAT_RANGE;
                     end else if (req_func == pale_pkg::FN_ALTER) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = ADDR_W'(req_position - POS_W'(1));
                        mem_req.wdata = WIDTH'(req_value);
                     end
                  end
                  default: begin
                     idx_in = '0;
                  end
               endcase
            end
         end
         pale_pkg::ST_INSERT: begin
            // read downward, write each word one place up
            mem_req.re    = more_down;
            mem_req.raddr = ADDR_W'(idx_ff - CNT_W'(1));
            pend_in       = more_down;
            pend_addr_in  = mem_req.raddr;
            if (more_down) begin
               idx_in = idx_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pend_addr_ff + ADDR_W'(1);
               mem_req.wdata = mem_rdata;
            end else if (!more_down) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = ADDR_W'(pos_ff - POS_W'(1));
               mem_req.wdata = val_ff;
               cnt_in        = cnt_ff + CNT_W'(1);
            end
         end
         pale_pkg::ST_ERASE: begin
            // read upward, keep the first word, write the rest one place down
            mem_req.re    = more_up;
            mem_req.raddr = idx_ff[ADDR_W-1:0];
            pend_in       = more_up;
            pend_addr_in  = idx_ff[ADDR_W-1:0];
            if (more_up) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (pend_addr_ff == ADDR_W'(pos_ff - POS_W'(1))) begin
                  res_in.removed_value = VAL_W'(mem_rdata);
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = pend_addr_ff - ADDR_W'(1);
                  mem_req.wdata = mem_rdata;
               end
            end else if (!more_up) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         pale_pkg::ST_SEARCH: begin
            mem_req.re    = more_up && !hit;
            mem_req.raddr = idx_ff[ADDR_W-1:0];
            pend_in       = more_up && !hit;
            pend_addr_in  = idx_ff[ADDR_W-1:0];
            if (more_up) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (hit) begin
               res_in.found_position = POS_W'(CNT_W'(pend_addr_ff) + CNT_W'(1));
            end else if (!pend_ff && !more_up) begin
               res_in.status = pale_pkg::STAT_MISS;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pale_pkg::ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      res_ff       <= res_in;
   end

endmodule

`default_nettype wire

// ===== src/positional_array_list_engine.sv =====
// Top level of the positional array list engine.
//
// Keeps an ordered list of up to DEPTH unsigned words, positions counted from 1.
// Request channel (req_): tuser carries the operation (insert, erase, alter,
// search), tdata the position and the value. Response channel (rsp_): tuser
// carries the status, tdata the found position, the removed value and the
// list length after the operation. One response per request transfer.
//
// One request is worked on at a time; req_tready is high only while the
// sequencer is idle. Alter and every rejected request go from the accept
// straight to the finish state. Insert, erase and search walk the entries
// between the addressed position and the tail (search from the head)
// through the single-port-read entry RAM, one entry per cycle, and then
// drain the last read before they finish.
//
// Reset empties the list and drops any pending response; stored words are
// not cleared. A response waits in an output register while rsp_tready is
// low, and the next request is still taken and worked up to its result.
`default_nettype none

module positional_array_list_engine (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [pale_pkg::REQ_DATA_W-1:0]    req_tdata,  // position, value
   input  wire logic [pale_pkg::FUNC_W-1:0]        req_tuser,  // func
   // response channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [pale_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // found_position,
                                                               // removed_value, length
   output logic      [pale_pkg::STAT_W-1:0]        rsp_tuser   // status
);

   localparam int POS_W = pale_pkg::POS_W;
   localparam int VAL_W = pale_pkg::VAL_W;

   pale_pkg::func_type            req_func;
   logic [POS_W-1:0]              req_position;
   logic [VAL_W-1:0]              req_value;

   logic                          res_valid;
   logic                          res_ready;
   pale_pkg::res_type             res;
   logic [pale_pkg::LEN_W-1:0]    res_length;

   pale_pkg::mem_req_type         mem_req;
   logic [pale_pkg::WIDTH-1:0]    mem_rdata;

   // output register
   logic                          out_valid_ff, out_valid_in;
   pale_pkg::res_type             out_res_ff;
   logic [pale_pkg::LEN_W-1:0]    out_len_ff;

   // unpack the request
   assign req_func     = pale_pkg::func_type'(req_tuser);
   assign req_position = req_tdata[POS_W-1:0];
   assign req_value    = req_tdata[POS_W+VAL_W-1:POS_W];

   pale_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .res_length   (res_length),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata)
   );

   pale_ram #(
      .DATA_W (pale_pkg::WIDTH),
      .ADDR_W (pale_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.we),
      .wr_addr (mem_req.waddr),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.re),
      .rd_addr (mem_req.raddr),
      .rd_data (mem_rdata)
   );

   // take a finished result when the output register is empty or draining
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the payload until the transfer
   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_res_ff <= res;
         out_len_ff <= res_length;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.status;
   assign rsp_tdata  = pale_pkg::RSP_DATA_W'({out_len_ff,
                                              out_res_ff.removed_value,
                                              out_res_ff.found_position});

endmodule

`default_nettype wire

// ===== src/pale_chk.sv =====
// Port checker for the positional array list engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pale_chk (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [pale_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [pale_pkg::STAT_W-1:0]     rsp_tuser
);

   // response fields
   logic [pale_pkg::POS_W-1:0] found_position;
   logic [pale_pkg::VAL_W-1:0] removed_value;
   logic [pale_pkg::LEN_W-1:0] length;

   assign found_position = rsp_tdata[pale_pkg::POS_W-1:0];
   assign removed_value  = rsp_tdata[pale_pkg::POS_W+pale_pkg::VAL_W-1:pale_pkg::POS_W];
   assign length         = rsp_tdata[pale_pkg::RSP_FIELD_W-1:pale_pkg::POS_W+pale_pkg::VAL_W];

   `PALE_ASSERT_ALWAYS(a_reset_drops_rsp, reset |=> !rsp_tvalid, "response valid after reset")

   `PALE_ASSERT(a_one_at_a_time, (req_tvalid && req_tready) |=> !req_tready, "second request taken while busy")

   `PALE_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled response changed")

   `PALE_ASSERT(a_fail_zero, (rsp_tvalid && (rsp_tuser != pale_pkg::STAT_OK)) |-> ((found_position == '0) && (removed_value == '0)), "failed request carries data")

   `PALE_ASSERT(a_found_in_list, rsp_tvalid |-> (found_position <= length), "found position beyond length")

endmodule

bind positional_array_list_engine pale_chk u_pale_chk (.*);

`default_nettype wire
